// ----- sv/cpr_pkg.sv -----
// Shared constants, codes and types for the colour-ID pick resolver.
// Used by cpr_entry_store, cpr_mark_store and color_id_pick_resolver_unit.
package cpr_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int COLOR_W     = 24;
    localparam int LIMIT_W     = 11;
    localparam int HIT_W       = 10;
    localparam int KIND_W      = 3;
    localparam int EPOCH_W     = 8;

    localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    localparam logic [KIND_W-1:0] KIND_RESET_LIST = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD_ENTRY  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BEGIN_SCAN = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SCAN_PIXEL = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LOOKUP     = 3'd4;

    localparam logic               REG_RESULT_LIMIT = 1'b0;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET      = 11'd1024;

    typedef struct packed {
        logic [7:0]  item_type;
        logic [15:0] main_index;
        logic [15:0] sub_index;
    } entry_t;

    typedef struct packed {
        logic             set;
        logic             clr;
        logic             flush;
        logic [IDX_W-1:0] addr;
    } mark_req_t;

    typedef struct packed {
        logic busy;
        logic wrap;
    } mark_stat_t;

endpackage

// ----- sv/cpr_entry_store.sv -----
// Entry table: one-port-read, one-port-write synchronous memory of entries.
// Forwards the write made in the same cycle as the read. Depends on cpr_pkg.
module cpr_entry_store (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    rd_en,
    input  logic [cpr_pkg::IDX_W-1:0] rd_addr,
    input  logic                    wr_en,
    input  logic [cpr_pkg::IDX_W-1:0] wr_addr,
    input  cpr_pkg::entry_t         wr_data,
    output cpr_pkg::entry_t         rd_data
);
    import cpr_pkg::*;

    entry_t           mem [TABLE_DEPTH];
    entry_t           rd_data_reg;
    logic [IDX_W-1:0] rd_addr_reg;
    logic             fwd_valid_reg;
    logic [IDX_W-1:0] fwd_addr_reg;
    entry_t           fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_valid_reg <= 1'b0;
        else if (wr_en)
            fwd_valid_reg <= 1'b1;
    end

    // take the latest write when it landed in the read cycle
    assign rd_data = (fwd_valid_reg && (fwd_addr_reg == rd_addr_reg)) ? fwd_data_reg
                                                                        : rd_data_reg;

endmodule

// ----- sv/cpr_mark_store.sv -----
// Hit-mark memory: one epoch tag per entry, a mark counts when it equals the epoch.
// Holds the epoch counter and the clearing sweep. Depends on cpr_pkg.
module cpr_mark_store (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [cpr_pkg::IDX_W-1:0] rd_addr,
    input  cpr_pkg::mark_req_t        req,
    output logic                      marked,
    output cpr_pkg::mark_stat_t       stat
);
    import cpr_pkg::*;

    logic [EPOCH_W-1:0] mem [TABLE_DEPTH];
    logic [EPOCH_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]   rd_addr_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic               sweep_reg;
    logic [IDX_W-1:0]   sweep_addr_reg;
    logic               fwd_valid_reg;
    logic [IDX_W-1:0]   fwd_addr_reg;
    logic [EPOCH_W-1:0] fwd_data_reg;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [EPOCH_W-1:0] wr_data;
    logic [EPOCH_W-1:0] cur_tag;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = req.addr;
        wr_data = EPOCH_NONE;
        if (sweep_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = sweep_addr_reg;
        end
        else if (req.set)
        begin
            wr_en   = 1'b1;
            wr_data = epoch_reg;
        end
        else if (req.clr)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg      <= EPOCH_FIRST;
            sweep_reg      <= 1'b1;
            sweep_addr_reg <= '0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (sweep_reg)
                fwd_valid_reg <= 1'b0;
            else if (wr_en)
                fwd_valid_reg <= 1'b1;

            if (sweep_reg)
            begin
                if (sweep_addr_reg == IDX_W'(TABLE_DEPTH - 1))
                    sweep_reg <= 1'b0;
                else
                    sweep_addr_reg <= sweep_addr_reg + 1'b1;
            end
            else if (req.flush)
            begin
                // wrap: restart the tags and wipe every stale one
                if (epoch_reg == EPOCH_LAST)
                begin
                    epoch_reg      <= EPOCH_FIRST;
                    sweep_reg      <= 1'b1;
                    sweep_addr_reg <= '0;
                end
                else
                    epoch_reg <= epoch_reg + 1'b1;
            end
        end
    end

    assign cur_tag   = (fwd_valid_reg && (fwd_addr_reg == rd_addr_reg)) ? fwd_data_reg
                                                                          : rd_data_reg;
    assign marked    = (cur_tag == epoch_reg);
    assign stat.busy = sweep_reg;
    assign stat.wrap = (epoch_reg == EPOCH_LAST);

endmodule

// ----- sv/color_id_pick_resolver_unit.sv -----
// Top level of the colour-ID pick resolver: stream ports, APB register, control.
// Instantiates cpr_entry_store and cpr_mark_store; depends on cpr_pkg.
//
// Use: commands and pixels arrive on the slave stream, kind in s_tuser, the
// colour bytes and entry fields in s_tdata. Reset-list, add and begin-scan give
// no result; a scan pixel gives one on the first hit of a live entry while the
// hit count stays below result_limit; a lookup always gives one.
// Throughput: one transfer per cycle while the receiver keeps up and no clearing
// pass runs or starts. Both memories are read at the transfer edge and the item
// resolves in the next cycle; the result then passes through the output register,
// which drives m_tvalid. The rate is set by the single read port of each memory
// and the read-modify-write of the hit-mark memory, which forwards the write of
// the cycle before.
// Hit marks are tagged with an 8-bit scan epoch. After reset, and on every 255th
// reset-list or begin-scan, a clearing pass writes all TABLE_DEPTH mark entries
// while s_tready stays low; APB writes are taken as ever.
// When the receiver stalls the result waits in the output register; a result-bearing
// item in the resolve stage holds behind it and s_tready drops until room opens.
// result_limit lies at byte address 0 and resets to 1024.
module color_id_pick_resolver_unit (
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // red[7:0] green[15:8] blue[23:16] item_type[31:24]
                                   // main_index[47:32] sub_index[63:48]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // found[0] found_type[8:1] found_main[24:9]
                                   // found_sub[40:25] hit_number[50:41] zero[55:51]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cpr_pkg::*;

    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    // configuration register
    logic [LIMIT_W-1:0] result_limit_reg;

    // resolve stage
    logic               s1_valid_reg;
    logic [KIND_W-1:0]  s1_kind_reg;
    logic [COLOR_W-1:0] s1_color_reg;
    entry_t             s1_entry_reg;

    // counters
    logic [CNT_W-1:0]   entry_count_reg;
    logic [CNT_W-1:0]   scan_hits_reg;

    // output register
    logic               out_valid_reg;
    logic               out_found_reg;
    entry_t             out_entry_reg;
    logic [HIT_W-1:0]   out_hit_reg;

    logic               s_accept;
    logic [COLOR_W-1:0] in_color;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   s1_slot;
    logic               in_range;
    logic               below_limit;
    logic               table_room;
    logic               is_flush;
    logic               need_out;
    logic               out_free;
    logic               s1_fire;
    logic               tbl_wr_en;
    logic               pix_new;
    entry_t             tbl_rd_data;
    logic               marked;
    mark_req_t          mark_req;
    mark_stat_t         mark_stat;
    logic               cfg_write;

    // APB: always ready, one register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_RESULT_LIMIT) ? 32'(result_limit_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_limit_reg <= LIMIT_RESET;
        else if (cfg_write && (paddr[2] == REG_RESULT_LIMIT))
            result_limit_reg <= pwdata[LIMIT_W-1:0];
    end

    // issue both memory reads on the transfer; colour c names entry c-1
    assign in_color = s_tdata[23:0];
    assign rd_addr  = IDX_W'(in_color - COLOR_W'(1));
    assign s_accept = s_tvalid && s_tready;

    // decode the item in the resolve stage
    assign s1_slot     = IDX_W'(s1_color_reg - COLOR_W'(1));
    assign in_range    = (s1_color_reg != '0) && (s1_color_reg <= COLOR_W'(entry_count_reg));
    assign below_limit = CMP_W'(scan_hits_reg) < CMP_W'(result_limit_reg);
    assign table_room  = entry_count_reg < CNT_W'(TABLE_DEPTH);
    assign pix_new     = in_range && !marked;

    always_comb
    begin
        is_flush  = 1'b0;
        need_out  = 1'b0;
        tbl_wr_en = 1'b0;
        unique case (s1_kind_reg) inside
            KIND_RESET_LIST, KIND_BEGIN_SCAN:
                is_flush = 1'b1;
            KIND_ADD_ENTRY:
                tbl_wr_en = table_room;
            KIND_SCAN_PIXEL:
                need_out = pix_new && below_limit;
            KIND_LOOKUP:
                need_out = 1'b1;
            default:
                need_out = 1'b0;
        endcase
    end

    assign out_free = !out_valid_reg || m_tready;
    assign s1_fire  = s1_valid_reg && (!need_out || out_free);

    // hold off new transfers during the sweep and behind a flush that starts one
    assign s_tready = !mark_stat.busy
                      && !(s1_valid_reg && is_flush && mark_stat.wrap)
                      && (!s1_valid_reg || s1_fire);

    assign mark_req.set   = s1_fire && (s1_kind_reg == KIND_SCAN_PIXEL) && pix_new;
    assign mark_req.clr   = s1_fire && tbl_wr_en;
    assign mark_req.flush = s1_fire && is_flush;
    assign mark_req.addr  = tbl_wr_en ? IDX_W'(entry_count_reg) : s1_slot;

    cpr_entry_store u_entry_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (s_accept),
        .rd_addr (rd_addr),
        .wr_en   (s1_fire && tbl_wr_en),
        .wr_addr (IDX_W'(entry_count_reg)),
        .wr_data (s1_entry_reg),
        .rd_data (tbl_rd_data)
    );

    cpr_mark_store u_mark_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (s_accept),
        .rd_addr (rd_addr),
        .req     (mark_req),
        .marked  (marked),
        .stat    (mark_stat)
    );

    // resolve stage payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_kind_reg             <= s_tuser;
            s1_color_reg            <= in_color;
            s1_entry_reg.item_type  <= s_tdata[31:24];
            s1_entry_reg.main_index <= s_tdata[47:32];
            s1_entry_reg.sub_index  <= s_tdata[63:48];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            entry_count_reg <= '0;
            scan_hits_reg   <= '0;
        end
        else
        begin
            if (s_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s1_fire)
            begin
                if (s1_kind_reg == KIND_RESET_LIST)
                begin
                    entry_count_reg <= '0;
                    scan_hits_reg   <= '0;
                end
                else if (s1_kind_reg == KIND_BEGIN_SCAN)
                    scan_hits_reg <= '0;
                else if (tbl_wr_en)
                    entry_count_reg <= entry_count_reg + 1'b1;
                else if ((s1_kind_reg == KIND_SCAN_PIXEL) && need_out)
                    scan_hits_reg <= scan_hits_reg + 1'b1;
            end
        end
    end

    // output register: load on a resolved result, drop once taken
    always_ff @(posedge clk)
    begin
        if (s1_fire && need_out)
        begin
            if (s1_kind_reg == KIND_LOOKUP)
            begin
                out_found_reg <= in_range;
                out_entry_reg <= in_range ? tbl_rd_data : '0;
                out_hit_reg   <= '0;
            end
            else
            begin
                out_found_reg <= 1'b1;
                out_entry_reg <= tbl_rd_data;
                out_hit_reg   <= HIT_W'(scan_hits_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire && need_out)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_hit_reg, out_entry_reg.sub_index,
                       out_entry_reg.main_index, out_entry_reg.item_type, out_found_reg};

    // no transfer while the mark sweep runs
    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        mark_stat.busy |-> !s_tready)
        else $error("transfer taken during mark sweep");

    a_hits_within_count: assert property (@(posedge clk) disable iff (!rst_n)
        scan_hits_reg <= entry_count_reg)
        else $error("hit count passed entry count");

    a_count_within_depth: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count passed table depth");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[50:1] == '0))
        else $error("not-found result carries data");

endmodule

// ----- tb/pick_result_checker.sv -----
// Scoreboard for the colour-ID pick resolver: watches both stream channels and APB writes.
// Keeps its own entry table, hit marks and counters; types and codes come from cpr_pkg.
`timescale 1ns / 1ps

module pick_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // red[7:0] green[15:8] blue[23:16] item_type[31:24]
                                   // main_index[47:32] sub_index[63:48]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,   // found[0] found_type[8:1] found_main[24:9]
                                   // found_sub[40:25] hit_number[50:41] zero[55:51]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          pending,
    output int          results_seen
);
    import cpr_pkg::*;

    localparam logic [2:0] LIMIT_ADDR = 3'(4 * REG_RESULT_LIMIT);
    localparam int         REPORT_MAX = 10;

    // First member sits in the top bits, so found lands in bit 0.
    typedef struct packed {
        logic [4:0]  pad;
        logic [9:0]  hit_number;
        logic [15:0] found_sub;
        logic [15:0] found_main;
        logic [7:0]  found_type;
        logic        found;
    } pick_t;

    entry_t             shadow_table [TABLE_DEPTH];
    bit                 shadow_marks [TABLE_DEPTH];
    int unsigned        live_entries;
    int unsigned        scan_count;
    logic [LIMIT_W-1:0] hit_limit;
    pick_t              expected_picks [$];
    pick_t              got;
    pick_t              want;
    pick_t              res;
    int                 fail_total;
    int                 seen_total;

    function automatic void clear_marks();
        foreach (shadow_marks[i])
            shadow_marks[i] = 1'b0;
    endfunction

    // Advance the shadow state by one input item; return 1 when it yields a result.
    function automatic bit resolve_pick(input logic [2:0] kind, input logic [63:0] data,
                                        output pick_t pick);
        logic [23:0] colour;
        bit          live;
        entry_t      hit_entry;
        colour = data[23:0];
        live   = (colour != 24'd0) && (int'(colour) <= int'(live_entries));
        pick   = '0;
        case (kind)
            KIND_RESET_LIST:
            begin
                live_entries = 0;
                scan_count   = 0;
                clear_marks();
                return 1'b0;
            end
            KIND_ADD_ENTRY:
            begin
                if (live_entries < TABLE_DEPTH)
                begin
                    shadow_table[live_entries] = {data[31:24], data[47:32], data[63:48]};
                    shadow_marks[live_entries] = 1'b0;
                    live_entries++;
                end
                return 1'b0;
            end
            KIND_BEGIN_SCAN:
            begin
                clear_marks();
                scan_count = 0;
                return 1'b0;
            end
            KIND_SCAN_PIXEL:
            begin
                if (!live || shadow_marks[colour - 1])
                    return 1'b0;
                shadow_marks[colour - 1] = 1'b1;
                // Marks still advance once the limit is reached; only reporting stops.
                if (scan_count >= hit_limit)
                    return 1'b0;
                hit_entry        = shadow_table[colour - 1];
                pick.found       = 1'b1;
                pick.found_type  = hit_entry.item_type;
                pick.found_main  = hit_entry.main_index;
                pick.found_sub   = hit_entry.sub_index;
                pick.hit_number  = 10'(scan_count);
                scan_count++;
                return 1'b1;
            end
            KIND_LOOKUP:
            begin
                if (live)
                begin
                    hit_entry       = shadow_table[colour - 1];
                    pick.found      = 1'b1;
                    pick.found_type = hit_entry.item_type;
                    pick.found_main = hit_entry.main_index;
                    pick.found_sub  = hit_entry.sub_index;
                end
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_marks();
            live_entries = 0;
            scan_count   = 0;
            hit_limit    = LIMIT_RESET;
            fail_total   = 0;
            seen_total   = 0;
            expected_picks.delete();
            mismatches   <= 0;
            pending      <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
                hit_limit = pwdata[LIMIT_W-1:0];

            // Check the result first: an item taken at this edge cannot show yet.
            if (m_tvalid && m_tready)
            begin
                got = pick_t'(m_tdata);
                seen_total++;
                if (expected_picks.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= REPORT_MAX)
                        $display("%0t: result with nothing expected: ", $time,
                                 "found=%0d type=%02h main=%04h sub=%04h hit=%0d",
                                 got.found, got.found_type, got.found_main,
                                 got.found_sub, got.hit_number);
                end
                else
                begin
                    want = expected_picks.pop_front();
                    if (got !== want)
                    begin
                        fail_total++;
                        if (fail_total <= REPORT_MAX)
                            $display("%0t: result differs: ", $time,
                                     "expected found=%0d type=%02h main=%04h ",
                                     want.found, want.found_type, want.found_main,
                                     "sub=%04h hit=%0d pad=%0h, ",
                                     want.found_sub, want.hit_number, want.pad,
                                     "got found=%0d type=%02h main=%04h ",
                                     got.found, got.found_type, got.found_main,
                                     "sub=%04h hit=%0d pad=%0h",
                                     got.found_sub, got.hit_number, got.pad);
                    end
                end
            end

            if (s_tvalid && s_tready)
                if (resolve_pick(s_tuser, s_tdata, res))
                    expected_picks.push_back(res);

            mismatches   <= fail_total;
            pending      <= expected_picks.size();
            results_seen <= seen_total;
        end
    end

endmodule

// ----- tb/color_id_pick_resolver_unit_tb.sv -----
// Top of the pick resolver testbench: clock, reset, stimulus and final verdict.
// Instantiates color_id_pick_resolver_unit and pick_result_checker; uses cpr_pkg.
`timescale 1ns / 1ps

module color_id_pick_resolver_unit_tb;
    import cpr_pkg::*;

    localparam int         HALF_PERIOD    = 10;
    localparam int         RESET_CYCLES   = 10;
    localparam int         IDLE_PCT       = 14;
    // Longest quiet spell is the mark clearing pass over all TABLE_DEPTH entries.
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         DRAIN_CYCLES   = 8;
    localparam int         CHURN_ROUNDS   = 270;
    localparam int         SCAN_SAMPLE    = 200;
    localparam logic [2:0] LIMIT_ADDR     = 3'(4 * REG_RESULT_LIMIT);
    // Kinds 5 to 7 carry no meaning; the block must drop them.
    localparam logic [2:0] KIND_UNUSED_LO = 3'd5;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int pending;
    int results_seen;

    int items_sent     = 0;
    int shadow_entries = 0;
    int phases         = 0;
    int limit_writes   = 0;
    int stall_cycles   = 0;
    bit quiet          = 1'b0;

    color_id_pick_resolver_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    pick_result_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Receiver: stall at random unless a quiet stretch is in force.
    always @(posedge clk)
        m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);

    // Watchdog: count cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired after %0d idle cycles", stall_cycles);
            $display("color_id_pick_resolver_unit: mismatch");
            $finish;
        end
    end

    // Pixel payload: colour in the low bytes, junk in the entry fields.
    function automatic logic [63:0] pixel_data(input logic [23:0] colour);
        return {16'($urandom), 16'($urandom), 8'($urandom), colour};
    endfunction

    function automatic logic [63:0] entry_data(input logic [7:0] kind_code,
                                               input logic [15:0] main_v,
                                               input logic [15:0] sub_v);
        return {sub_v, main_v, kind_code, 24'($urandom)};
    endfunction

    function automatic logic [63:0] junk_data();
        return {$urandom, $urandom};
    endfunction

    // Mostly live colours, with background, just-past-the-end and wild ones mixed in.
    function automatic logic [23:0] pick_colour();
        int unsigned sel;
        sel = $urandom_range(99);
        if (shadow_entries > 0 && sel < 65)
            return 24'($urandom_range(shadow_entries, 1));
        if (sel < 75)
            return 24'd0;
        if (sel < 85)
            return 24'(shadow_entries + $urandom_range(3, 1));
        return 24'($urandom);
    endfunction

    function automatic int unsigned pick_limit();
        case ($urandom_range(7))
            0:       return 0;
            1:       return 1;
            2:       return 2;
            3:       return $urandom_range(30, 3);
            4:       return 1024;
            5:       return 2047;
            6:       return $urandom_range(2046, 1025);
            default: return $urandom_range(2047);
        endcase
    endfunction

    // Offer one item and hold it until the transfer; sample ready at the falling edge.
    task automatic push_item(input logic [2:0] kind, input logic [63:0] data);
        bit rdy;
        if (!quiet)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do
        begin
            @(negedge clk);
            rdy = s_tready;
            @(posedge clk);
        end
        while (!rdy);
        items_sent++;
        if (kind == KIND_RESET_LIST)
            shadow_entries = 0;
        else if (kind == KIND_ADD_ENTRY && shadow_entries < TABLE_DEPTH)
            shadow_entries++;
    endtask

    // Drop valid, wait for every expected result, then let the pipeline drain.
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input int unsigned value);
        bit rdy;
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            rdy = pready;
            @(posedge clk);
        end
        while (!rdy);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        limit_writes++;
    endtask

    // Phases: optional limit change, list build, then one or more scans with stray items mixed in.
    task automatic run_phases(input int stop_at);
        int          n;
        int unsigned sel;
        while (items_sent < stop_at)
        begin
            phases++;
            if ($urandom_range(9) < 4)
                write_limit(pick_limit());
            if ($urandom_range(3) == 0 || shadow_entries > TABLE_DEPTH - 64)
                push_item(KIND_RESET_LIST, junk_data());
            repeat ($urandom_range(24, 1))
                push_item(KIND_ADD_ENTRY,
                          entry_data(8'($urandom), 16'($urandom), 16'($urandom)));
            repeat ($urandom_range(3, 1))
            begin
                // Now and then carry on the previous scan without a fresh begin.
                if ($urandom_range(9) != 0)
                    push_item(KIND_BEGIN_SCAN, junk_data());
                n = $urandom_range(30, 4);
                repeat (n)
                begin
                    sel = $urandom_range(99);
                    if (sel < 68)
                        push_item(KIND_SCAN_PIXEL, pixel_data(pick_colour()));
                    else if (sel < 82)
                        push_item(KIND_LOOKUP, pixel_data(pick_colour()));
                    else if (sel < 88)
                        push_item(KIND_ADD_ENTRY,
                                  entry_data(8'($urandom), 16'($urandom), 16'($urandom)));
                    else if (sel < 93)
                        push_item(KIND_UNUSED_LO + 3'($urandom_range(2)), junk_data());
                    else if (sel < 97)
                        push_item(KIND_BEGIN_SCAN, junk_data());
                    else
                        push_item(KIND_RESET_LIST, junk_data());
                end
            end
            // Hold the sender off until every result of the phase is in.
            settle();
        end
    endtask

    initial
    begin
        int colours [TABLE_DEPTH];
        int pos;
        int tmp;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, limit still at its reset value.
        push_item(KIND_LOOKUP, pixel_data(24'd0));          // empty table: not found
        push_item(KIND_SCAN_PIXEL, pixel_data(24'd1));      // no entry yet: silent
        push_item(KIND_ADD_ENTRY, entry_data(8'hFF, 16'h7FFF, 16'h8000));
        push_item(KIND_ADD_ENTRY, entry_data(8'h00, 16'h8000, 16'h7FFF));
        push_item(KIND_ADD_ENTRY, entry_data(8'hA5, 16'hFFFF, 16'h0000));
        push_item(KIND_LOOKUP, pixel_data(24'd1));
        push_item(KIND_LOOKUP, pixel_data(24'd2));
        push_item(KIND_LOOKUP, pixel_data(24'd3));
        push_item(KIND_LOOKUP, pixel_data(24'd4));          // one past the end
        push_item(KIND_LOOKUP, pixel_data(24'hFFFFFF));
        push_item(KIND_UNUSED_LO, junk_data());
        push_item(KIND_UNUSED_LO + 3'd1, junk_data());
        push_item(KIND_UNUSED_LO + 3'd2, junk_data());
        push_item(KIND_BEGIN_SCAN, junk_data());
        push_item(KIND_SCAN_PIXEL, pixel_data(24'd2));
        push_item(KIND_SCAN_PIXEL, pixel_data(24'd2));      // already hit
        push_item(KIND_SCAN_PIXEL, pixel_data(24'd0));      // background
        push_item(KIND_SCAN_PIXEL, pixel_data(24'd4));      // unknown colour
        push_item(KIND_SCAN_PIXEL, pixel_data(24'd1));
        push_item(KIND_SCAN_PIXEL, pixel_data(24'd3));
        push_item(KIND_LOOKUP, pixel_data(24'd2));          // ignores hit marks
        push_item(KIND_RESET_LIST, junk_data());
        push_item(KIND_LOOKUP, pixel_data(24'd1));          // cleared list: not found
        settle();

        run_phases(items_sent + 200);

        // Fill the table past its depth, then hit a shuffled sample of its entries once.
        write_limit(1024);
        push_item(KIND_RESET_LIST, junk_data());
        repeat (TABLE_DEPTH + 6)
            push_item(KIND_ADD_ENTRY,
                      entry_data(8'($urandom), 16'($urandom), 16'($urandom)));
        push_item(KIND_LOOKUP, pixel_data(24'(TABLE_DEPTH)));
        push_item(KIND_LOOKUP, pixel_data(24'(TABLE_DEPTH + 1)));
        push_item(KIND_BEGIN_SCAN, junk_data());
        foreach (colours[i])
            colours[i] = i + 1;
        for (int i = TABLE_DEPTH - 1; i > 0; i--)
        begin
            pos          = $urandom_range(i);
            tmp          = colours[i];
            colours[i]   = colours[pos];
            colours[pos] = tmp;
        end
        for (int i = 0; i < SCAN_SAMPLE; i++)
        begin
            push_item(KIND_SCAN_PIXEL, pixel_data(24'(colours[i])));
            if ($urandom_range(19) == 0)
                push_item(KIND_SCAN_PIXEL, pixel_data(pick_colour()));
        end
        push_item(KIND_SCAN_PIXEL, pixel_data(24'(TABLE_DEPTH + 1)));
        settle();

        run_phases(items_sent + 100);

        // Back-to-back begin-scans with no idling, enough to roll the scan epoch over.
        quiet = 1'b1;
        push_item(KIND_RESET_LIST, junk_data());
        repeat (6)
            push_item(KIND_ADD_ENTRY,
                      entry_data(8'($urandom), 16'($urandom), 16'($urandom)));
        repeat (CHURN_ROUNDS)
        begin
            push_item(KIND_BEGIN_SCAN, junk_data());
            if ($urandom_range(3) == 0)
            begin
                tmp = $urandom_range(shadow_entries, 1);
                push_item(KIND_SCAN_PIXEL, pixel_data(24'(tmp)));
                if ($urandom_range(3) == 0)
                    push_item(KIND_SCAN_PIXEL, pixel_data(24'(tmp)));
            end
        end
        quiet = 1'b0;
        settle();

        run_phases(items_sent + 100);

        settle();
        $display("sent %0d items over %0d phases with %0d limit writes; %0d results checked",
                 items_sent, phases, limit_writes, results_seen);
        $display("covered a full table, every kind, the limit extremes and a scan epoch wrap");
        if (mismatches == 0 && pending == 0)
            $display("color_id_pick_resolver_unit: match");
        else
        begin
            $display("%0d failures, %0d results still outstanding", mismatches, pending);
            $display("color_id_pick_resolver_unit: mismatch");
        end
        $finish;
    end

endmodule
